[sv/lph_pkg.sv]
package lph_pkg;

  // field widths
  localparam int NOW_W    = 64;
  localparam int WAIT_W   = 32;
  localparam int NAP_W    = 17;
  localparam int SLEEP_W  = 32;

  // internal widths
  localparam int NAP_US_W  = 37;  // nap in us, up to (2^17-1) * 10^6
  localparam int SPC_W     = 38;  // signed launch spacing in us
  localparam int WAIT_US_W = 41;  // positive queue wait in us
  localparam int DIFF_W    = NOW_W + 1;
  localparam int X_W       = 39;  // remaining time / 8, below 125 * 2^32
  localparam int HI_W      = 19;
  localparam int LO_W      = 20;
  localparam int Q1_W      = 13;
  localparam int R1_W      = 7;
  localparam int Y_W       = R1_W + LO_W;

  // time constants
  localparam logic [NAP_US_W-1:0]  US_PER_S  = 37'd1_000_000;
  localparam logic [WAIT_US_W-1:0] US_PER_MS = 41'd1_000;
  localparam logic [NAP_W-1:0]     HIB_NAP_S = 17'd60;
  localparam logic signed [SPC_W-1:0]  TOL_US = 38'sd20_000;
  localparam logic signed [DIFF_W-1:0] DRIFT_US = 65'sd1_000_000;
  localparam logic signed [DIFF_W-1:0] HIB_IDLE_US = 65'sd120_000_000;
  // 1000 * 2^32 us: at or above this the sleep saturates
  localparam logic [NOW_W-1:0] SAT_US = 64'h0000_03E8_0000_0000;

  // divide by 125 through reciprocals; both exact over the ranges used
  localparam logic [19:0] RECIP1 = 20'd536_871;      // ceil(2^26 / 125)
  localparam int          SHIFT1 = 26;
  localparam logic [27:0] RECIP2 = 28'd137_438_954;  // ceil(2^34 / 125)
  localparam int          SHIFT2 = 34;
  localparam logic [HI_W-1:0] DIV_K = 19'd125;

  // register reset values for a 10 s nap
  localparam logic [NAP_US_W-1:0]     NAP_US_RST     = 37'd10_000_000;
  localparam logic [NAP_US_W-1:0]     HIB_NAP_US_RST = 37'd60_000_000;
  localparam logic signed [SPC_W-1:0] SPC_US_RST     = 38'sd9_980_000;

  typedef struct packed {
    logic launch;
    logic hib;
    logic wake;
    logic zero;
    logic sat;
  } flags_t;

  typedef struct packed {
    logic                 func;
    logic [NOW_W-1:0]     now;
    logic                 wait_zero;
    logic                 wait_neg;
    logic [WAIT_US_W-1:0] wait_us;
  } s0_t;

  typedef struct packed {
    flags_t         flags;
    logic [X_W-1:0] x;
  } s1_t;

  typedef struct packed {
    flags_t          flags;
    logic [HI_W-1:0] hi;
    logic [LO_W-1:0] lo;
    logic [Q1_W-1:0] q1;
  } s2_t;

  typedef struct packed {
    flags_t          flags;
    logic [Q1_W-1:0] q1;
    logic [Y_W-1:0]  y;
  } s3_t;

endpackage

[sv/lph_if.sv]
interface lph_item_if import lph_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [NOW_W-1:0]  now_us;
  logic signed [WAIT_W-1:0] work_wait_ms;

  modport source (output valid, func, now_us, work_wait_ms, input ready);
  modport sink   (input valid, func, now_us, work_wait_ms, output ready);
endinterface

interface lph_result_if import lph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               launch;
  logic [SLEEP_W-1:0] sleep_ms;
  logic               hibernating;
  logic               wake_signal;

  modport source (output valid, launch, sleep_ms, hibernating, wake_signal, input ready);
  modport sink   (input valid, launch, sleep_ms, hibernating, wake_signal, output ready);
endinterface

[sv/launch_pacer_with_hibernation_top.sv]
// A word accepted from item passes the stage 0 to 3 registers and the stage 4 result register.
// Throughput: one word per cycle unless result.ready stalls it; the schedule state is updated
// in a single stage, so each word sees the state left by the word before it.
// Sleep is divided down over three further stages (two reciprocal multiplies).
// Reset (rst, synchronous): pipeline empty, schedule and flags cleared, nap = 10 s.
module launch_pacer_with_hibernation_top import lph_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lph_item_if.sink          item,
  lph_result_if.source      result,
  input  logic              cfg_we,
  input  logic [NAP_W-1:0]  cfg_wdata
);

  // configuration, kept in derived form
  logic [NAP_US_W-1:0]     nap_us;
  logic [NAP_US_W-1:0]     hib_nap_us;
  logic signed [SPC_W-1:0] spacing_us;
  logic [NAP_US_W-1:0]     cfg_nap_us;
  logic [NAP_W-1:0]        cfg_hib_s;

  // schedule state
  logic [NOW_W-1:0] last_launch;
  logic [NOW_W-1:0] sleep_until;
  logic             hib;
  logic             started;

  // pipeline
  logic v0, v1, v2, v3;
  logic en0, en1, en2, en3, en4;
  s0_t  s0;
  s1_t  s1, s1_next;
  s2_t  s2;
  s3_t  s3;

  // stage 1 combinational terms
  logic [NOW_W-1:0]        ll0, su0, ll1, su1, su2, ll2, rem;
  logic signed [DIFF_W-1:0] dd, dl, spc_ext;
  logic                    back, drift, spaced, hib_due, ahead, hib_next, launch_w;
  logic [WAIT_US_W-1:0]    tout;
  logic [HI_W+19:0]        prod1;
  logic [Y_W+27:0]         prod2;
  logic [HI_W-1:0]         r1;

  // flow control: each stage moves when its successor has room
  assign en4 = !result.valid || result.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign item.ready = en0;

  // config products
  always_comb begin
    cfg_hib_s  = (cfg_wdata < HIB_NAP_S) ? HIB_NAP_S : cfg_wdata;
    cfg_nap_us = NAP_US_W'(cfg_wdata) * US_PER_S;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nap_us     <= NAP_US_RST;
      hib_nap_us <= HIB_NAP_US_RST;
      spacing_us <= SPC_US_RST;
    end else if (cfg_we) begin
      nap_us     <= cfg_nap_us;
      hib_nap_us <= NAP_US_W'(cfg_hib_s) * US_PER_S;
      spacing_us <= $signed({1'b0, cfg_nap_us}) - TOL_US;
    end
  end

  // stage 0: input register, queue wait scaled to us
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && item.valid) begin
      s0.func      <= item.func;
      s0.now       <= item.now_us;
      s0.wait_zero <= (item.work_wait_ms == '0);
      s0.wait_neg  <= item.work_wait_ms[WAIT_W-1];
      s0.wait_us   <= WAIT_US_W'(item.work_wait_ms[WAIT_W-2:0]) * US_PER_MS;
    end
  end

  // stage 1: schedule update
  always_comb begin
    // first wake anchors as if the nap just ran out
    ll0 = started ? last_launch : s0.now - NOW_W'(nap_us);
    su0 = started ? sleep_until : s0.now;

    back  = $signed(s0.now) < $signed(ll0);
    dd    = $signed({s0.now[NOW_W-1], s0.now}) - $signed({su0[NOW_W-1], su0});
    drift = (dd >= DRIFT_US) || (dd <= -DRIFT_US);

    ll1 = back ? s0.now : ll0;
    su1 = (back || drift) ? s0.now : su0;

    dl      = $signed({s0.now[NOW_W-1], s0.now}) - $signed({ll1[NOW_W-1], ll1});
    spc_ext = DIFF_W'(spacing_us);
    spaced  = dl >= spc_ext;
    hib_due = dl >= HIB_IDLE_US;

    // timeout for the next wake
    launch_w = 1'b0;
    hib_next = hib;
    ll2      = ll1;
    tout     = WAIT_US_W'(nap_us);
    priority if (s0.wait_zero) begin
      launch_w = 1'b1;
      ll2      = su1;
    end else if (!s0.wait_neg) begin
      if (s0.wait_us < WAIT_US_W'(nap_us)) tout = s0.wait_us;
    end else begin
      hib_next = hib || hib_due;
      if (hib_next) tout = WAIT_US_W'(hib_nap_us);
    end

    if (!spaced) begin
      launch_w = 1'b0;
      hib_next = hib;
      ll2      = ll1;
      su2      = ll1 + NOW_W'(nap_us);
    end else begin
      su2 = su1 + NOW_W'(tout);
    end

    ahead = $signed(s0.now) < $signed(su2);
    rem   = su2 - s0.now;

    s1_next.flags.launch = launch_w;
    s1_next.flags.hib    = hib_next;
    s1_next.flags.wake   = 1'b0;
    s1_next.flags.zero   = !ahead;
    s1_next.flags.sat    = rem >= SAT_US;
    s1_next.x            = rem[X_W+2:3];

    // disturb: clears hibernation and flags a wake if it was hibernating; no launch, no sleep
    if (s0.func) begin
      s1_next.flags.launch = 1'b0;
      s1_next.flags.hib    = 1'b0;
      s1_next.flags.wake   = hib;
      s1_next.flags.zero   = 1'b1;
      s1_next.flags.sat    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      last_launch <= '0;
      sleep_until <= '0;
      hib         <= 1'b0;
      started     <= 1'b0;
    end else if (en1) begin
      v1 <= v0;
      if (v0) begin
        hib <= s1_next.flags.hib;
        if (!s0.func) begin
          started     <= 1'b1;
          last_launch <= ll2;
          sleep_until <= su2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v0) s1 <= s1_next;
  end

  // stage 2: upper quotient digit of x / 125
  assign prod1 = s1.x[X_W-1:LO_W] * RECIP1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2.flags <= s1.flags;
      s2.hi    <= s1.x[X_W-1:LO_W];
      s2.lo    <= s1.x[LO_W-1:0];
      s2.q1    <= prod1[SHIFT1 +: Q1_W];
    end
  end

  // stage 3: remainder of the upper digit joins the lower bits
  assign r1 = s2.hi - HI_W'(s2.q1) * DIV_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3.flags <= s2.flags;
      s3.q1    <= s2.q1;
      s3.y     <= {r1[R1_W-1:0], s2.lo};
    end
  end

  // stage 4: lower quotient digit, result register
  assign prod2 = s3.y * RECIP2;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en4) begin
      result.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      result.launch      <= s3.flags.launch;
      result.hibernating <= s3.flags.hib;
      result.wake_signal <= s3.flags.wake;
      priority if (s3.flags.zero) begin
        result.sleep_ms <= '0;
      end else if (s3.flags.sat) begin
        result.sleep_ms <= '1;
      end else begin
        result.sleep_ms <= {s3.q1[SLEEP_W-LO_W-1:0], prod2[SHIFT2 +: LO_W]};
      end
    end
  end

  // a word that raises the wake signal never launches, sleeps or hibernates
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.wake_signal |->
      !result.launch && !result.hibernating && (result.sleep_ms == '0))
    else $error("disturb word carries launch, sleep or hibernation");

  // once a wake is seen the schedule stays anchored
  assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started flag dropped");

  // upper quotient digit fits the 32-bit sleep when not saturated
  assert property (@(posedge clk) disable iff (rst)
    v2 && !s2.flags.zero && !s2.flags.sat |-> !s2.q1[Q1_W-1])
    else $error("upper quotient digit out of range");

endmodule
